>>> sv/pds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the particle depth sorter.
package pds_pkg;

  localparam int IDX_W   = 10;
  localparam int KEY_W   = 48;
  localparam int POS_W   = 32;
  localparam int FWD_W   = 16;
  localparam int BIRTH_W = 16;
  localparam int CNT_OUT_W = 11;
  localparam int RANK_W  = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MODE_NONE       = 3'd0,
    MODE_BIRTH_ASC  = 3'd1,
    MODE_BIRTH_DESC = 3'd2,
    MODE_NEAR       = 3'd3,
    MODE_FAR        = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X = 3'd0,
    REG_CAM_Y = 3'd1,
    REG_CAM_Z = 3'd2,
    REG_FWD_X = 3'd3,
    REG_FWD_Y = 3'd4,
    REG_FWD_Z = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_DROP,
    KIND_MISS,
    KIND_READ,
    KIND_INSERT
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_SEEK,
    S_CMP,
    S_PLACE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  in_ready;
    logic  cap;
    logic  mul;
    logic  sum;
    logic  rd_en;
    logic  rd_rank;
    logic  wr_en;
    logic  wr_new;
    logic  pos_load;
    logic  pos_dec;
    logic  cnt_clear;
    logic  cnt_inc;
    logic  out_load;
    kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    full;
    logic    rank_ok;
    logic    pos_zero;
    logic    less;
    logic    out_busy;
  } sts_t;

endpackage

>>> sv/pds_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the particle depth sorter.
module pds_ctrl
  import pds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= KIND_CLEAR;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cmd        = '0;
    cmd.out_kind = kind;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          unique case (sts.action)
            ACT_CLEAR: begin
              cmd.cnt_clear = 1'b1;
              kind_next  = KIND_CLEAR;
              state_next = S_DONE;
            end
            ACT_INSERT: begin
              if (sts.full) begin
                kind_next  = KIND_DROP;
                state_next = S_DONE;
              end else begin
                state_next = S_MUL;
              end
            end
            ACT_READ: begin
              if (sts.rank_ok) begin
                cmd.rd_en   = 1'b1;
                cmd.rd_rank = 1'b1;
                kind_next   = KIND_READ;
                state_next  = S_READ;
              end else begin
                kind_next  = KIND_MISS;
                state_next = S_DONE;
              end
            end
            default: begin
              kind_next  = KIND_MISS;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum      = 1'b1;
        cmd.pos_load = 1'b1;
        state_next   = S_SEEK;
      end
      S_SEEK: begin
        if (sts.pos_zero) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.less) begin
          cmd.wr_en   = 1'b1;
          cmd.pos_dec = 1'b1;
          state_next  = S_SEEK;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
        kind_next   = KIND_INSERT;
        state_next  = S_DONE;
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/pds_datapath.sv
`timescale 1ns / 1ps
// Key arithmetic, sorted entry memory, count and result register.
module pds_datapath
  import pds_pkg::*;
#(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic [1:0]               action,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic [BIRTH_W-1:0]       birth_seq,
  input  logic [2:0]               sort_mode,
  input  logic                     additive_blend,
  input  logic [RANK_W-1:0]        rank,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         entry_index,
  output logic signed [KEY_W-1:0]  entry_key,
  output logic [CNT_OUT_W-1:0]     entry_count,
  output logic                     dropped,
  output logic                     rank_valid
);

  localparam int ADDR_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
  localparam int ENT_W  = KEY_W + IDX_W;
  localparam int DIF_W  = POS_W + 1;
  localparam int PRD_W  = DIF_W + FWD_W;
  localparam int SUM_W  = PRD_W + 2;

  logic signed [POS_W-1:0] cam_x, cam_y, cam_z;
  logic signed [FWD_W-1:0] fwd_x, fwd_y, fwd_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      fwd_x <= '0;
      fwd_y <= '0;
      fwd_z <= FWD_W'(16384);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_X: cam_x <= cfg_data;
        REG_CAM_Y: cam_y <= cfg_data;
        REG_CAM_Z: cam_z <= cfg_data;
        REG_FWD_X: fwd_x <= cfg_data[FWD_W-1:0];
        REG_FWD_Y: fwd_y <= cfg_data[FWD_W-1:0];
        REG_FWD_Z: fwd_z <= cfg_data[FWD_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [DIF_W-1:0] dx, dy, dz;
  logic signed [PRD_W-1:0] px, py, pz;
  logic signed [SUM_W-1:0] dot;
  logic signed [KEY_W-1:0] depth, birth_key, key_new, key_sel;
  logic [BIRTH_W-1:0]      birth;
  logic [2:0]              mode;
  logic                    blend;
  logic [IDX_W-1:0]        new_idx;
  logic [CNT_W-1:0]        count;
  logic [ADDR_W-1:0]       pos;
  logic [31:0]             count32, rank32, pos32;

  assign count32 = 32'(count);
  assign rank32  = 32'(rank);
  assign pos32   = 32'(pos);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      dx    <= DIF_W'(pos_x) - DIF_W'(cam_x);
      dy    <= DIF_W'(pos_y) - DIF_W'(cam_y);
      dz    <= DIF_W'(pos_z) - DIF_W'(cam_z);
      birth <= birth_seq;
      mode  <= sort_mode;
      blend <= additive_blend;
    end
    if (cmd.mul) begin
      px <= dx * PRD_W'(fwd_x);
      py <= dy * PRD_W'(fwd_y);
      pz <= dz * PRD_W'(fwd_z);
    end
    if (cmd.sum) begin
      key_new <= key_sel;
    end
    if (cmd.pos_load) begin
      new_idx <= count32[IDX_W-1:0];
    end
  end

  assign dot       = SUM_W'(px) + SUM_W'(py) + SUM_W'(pz);
  assign depth     = KEY_W'(dot >>> 14);
  assign birth_key = KEY_W'({birth, 16'b0});

  always_comb begin
    unique case (mode)
      MODE_BIRTH_ASC:  key_sel = -birth_key;
      MODE_BIRTH_DESC: key_sel = birth_key;
      MODE_NEAR:       key_sel = -depth;
      MODE_FAR:        key_sel = depth;
      default:         key_sel = blend ? birth_key : depth;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clear) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_load) begin
      pos <= count32[ADDR_W-1:0];
    end else if (cmd.pos_dec) begin
      pos <= pos - ADDR_W'(1);
    end
  end

  logic [ENT_W-1:0]  mem [MAX_PARTICLES];
  logic [ENT_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENT_W-1:0]  wr_data;
  logic signed [KEY_W-1:0] rd_key;
  logic [IDX_W-1:0]  rd_idx;

  assign rd_addr = cmd.rd_rank ? rank32[ADDR_W-1:0] : pos - ADDR_W'(1);
  assign wr_data = cmd.wr_new ? {key_new, new_idx} : rd_data;
  assign rd_key  = rd_data[ENT_W-1:IDX_W];
  assign rd_idx  = rd_data[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[pos] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      entry_count <= count32[CNT_OUT_W-1:0];
      entry_index <= '0;
      entry_key   <= '0;
      dropped     <= 1'b0;
      rank_valid  <= 1'b0;
      unique case (cmd.out_kind)
        KIND_DROP: dropped <= 1'b1;
        KIND_READ: begin
          entry_index <= rd_idx;
          entry_key   <= rd_key;
          rank_valid  <= 1'b1;
        end
        KIND_INSERT: begin
          entry_index <= new_idx;
          entry_key   <= key_new;
        end
        default: ;
      endcase
    end
  end

  assign sts.action   = action_t'(action);
  assign sts.full     = (count == CNT_W'(MAX_PARTICLES));
  assign sts.rank_ok  = (rank32 < count32);
  assign sts.pos_zero = (pos32 == 32'd0);
  assign sts.less     = (rd_key < key_new);
  assign sts.out_busy = out_valid && out_stall;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count32 <= 32'(MAX_PARTICLES))
    else $error("entry count beyond capacity");
  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert placed into a full list");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwritten while held");
  a_seek_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && !cmd.rd_rank) |-> (pos32 != 32'd0))
    else $error("shift read below first entry");
`endif

endmodule

>>> sv/particle_depth_sorter.sv
`timescale 1ns / 1ps
// Particle depth sorter: keeps particles in stable descending key order.
//
// Input channel (in_valid / in_stall): one beat per clear, insert or read.
// Output channel (out_valid / out_stall): exactly one result beat per input beat,
// in order. Configuration: cfg_we writes cfg_data to register cfg_index.
// Steps: clear, failed read and dropped insert go straight to the result.
// Read: one memory read, then the result. Insert: multiply, sum, then a shift loop
// moves each entry with a smaller key one rank down before the new entry is placed;
// the loop moves one entry at a time through the entry memory (read, then write).
// One item is in flight at a time; the next beat is taken once the current
// result sits in the output register.
// Reset clears the entry count, the output valid and the camera registers;
// memory contents are not cleared, since only ranks below the count are read.
// While the receiver stalls, the held result stays and the block waits with
// in_stall high once its next result is ready.
module particle_depth_sorter
  import pds_pkg::*;
#(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic [BIRTH_W-1:0]       birth_seq,
  input  logic [2:0]               sort_mode,
  input  logic                     additive_blend,
  input  logic [RANK_W-1:0]        rank,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         entry_index,
  output logic signed [KEY_W-1:0]  entry_key,
  output logic [CNT_OUT_W-1:0]     entry_count,
  output logic                     dropped,
  output logic                     rank_valid,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign in_stall = !cmd.in_ready;

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  pds_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .birth_seq      (birth_seq),
    .sort_mode      (sort_mode),
    .additive_blend (additive_blend),
    .rank           (rank),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .entry_index    (entry_index),
    .entry_key      (entry_key),
    .entry_count    (entry_count),
    .dropped        (dropped),
    .rank_valid     (rank_valid)
  );

endmodule

>>> bench/particle_depth_sorter_tb.sv
`timescale 1ns / 1ps
// Testbench for the particle depth sorter: random and directed beats against a predictor.
module particle_depth_sorter_tb;
  import pds_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] entry_key;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    dropped;
    logic                    rank_valid;
  } sorted_result_t;

  class depth_scoreboard;
    logic signed [POS_W-1:0] cam_x, cam_y, cam_z;
    logic signed [FWD_W-1:0] fx, fy, fz;
    logic signed [KEY_W-1:0] keys [DEPTH];
    logic [IDX_W-1:0]        idxs [DEPTH];
    int                      held;
    sorted_result_t          pending [$];
    int                      mismatches;

    function new();
      cam_x = 0; cam_y = 0; cam_z = 0;
      fx = 0; fy = 0; fz = 16384;
      held = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_CAM_X: cam_x = v;
        REG_CAM_Y: cam_y = v;
        REG_CAM_Z: cam_z = v;
        REG_FWD_X: fx = v[FWD_W-1:0];
        REG_FWD_Y: fy = v[FWD_W-1:0];
        REG_FWD_Z: fz = v[FWD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [KEY_W-1:0] depth_key(logic signed [POS_W-1:0] px,
        logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz, logic [BIRTH_W-1:0] bo,
        logic [2:0] md, logic add);
      logic signed [63:0] dx, dy, dz, acc, dep, birth;
      dx = 64'(px) - 64'(cam_x);
      dy = 64'(py) - 64'(cam_y);
      dz = 64'(pz) - 64'(cam_z);
      acc = dx * 64'(fx) + dy * 64'(fy) + dz * 64'(fz);
      dep = acc >>> 14;
      birth = {32'd0, bo, 16'd0};
      case (md)
        MODE_BIRTH_ASC:  return KEY_W'(-birth);
        MODE_BIRTH_DESC: return KEY_W'(birth);
        MODE_NEAR:       return KEY_W'(-dep);
        MODE_FAR:        return KEY_W'(dep);
        default:         return add ? KEY_W'(birth) : KEY_W'(dep);
      endcase
    endfunction

    function void note_beat(logic [1:0] act, logic signed [POS_W-1:0] px,
        logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz, logic [BIRTH_W-1:0] bo,
        logic [2:0] md, logic add, logic [RANK_W-1:0] rk);
      sorted_result_t r;
      logic signed [KEY_W-1:0] k;
      int p;
      r = '{default: 0};
      if (act == ACT_CLEAR) begin
        held = 0;
      end else if (act == ACT_INSERT) begin
        if (held >= DEPTH) begin
          r.dropped = 1;
        end else begin
          k = depth_key(px, py, pz, bo, md, add);
          p = held;
          while (p > 0 && keys[p-1] < k) begin
            keys[p] = keys[p-1];
            idxs[p] = idxs[p-1];
            p--;
          end
          keys[p] = k;
          idxs[p] = IDX_W'(held);
          r.entry_index = IDX_W'(held);
          r.entry_key = k;
          held++;
        end
      end else if (act == ACT_READ) begin
        if (int'(rk) < held) begin
          r.entry_index = idxs[rk];
          r.entry_key = keys[rk];
          r.rank_valid = 1;
        end
      end
      r.entry_count = CNT_OUT_W'(held);
      pending.push_back(r);
    endfunction

    function void check_beat(sorted_result_t got);
      sorted_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: idx %0d key %0d",
          got.entry_index, got.entry_key);
        return;
      end
      e = pending.pop_front();
      if (got.entry_index !== e.entry_index || got.entry_key !== e.entry_key ||
          got.entry_count !== e.entry_count || got.dropped !== e.dropped ||
          got.rank_valid !== e.rank_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: exp idx %0d key %0d cnt %0d drop %0b rv %0b",
                    " / got idx %0d key %0d cnt %0d drop %0b rv %0b"},
            e.entry_index, e.entry_key, e.entry_count, e.dropped, e.rank_valid,
            got.entry_index, got.entry_key, got.entry_count, got.dropped,
            got.rank_valid);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] action;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [BIRTH_W-1:0] birth_seq;
  logic [2:0] sort_mode;
  logic additive_blend;
  logic [RANK_W-1:0] rank;
  logic [IDX_W-1:0] entry_index;
  logic signed [KEY_W-1:0] entry_key;
  logic [CNT_OUT_W-1:0] entry_count;
  logic dropped, rank_valid;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  depth_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  int quiet_cycles;

  particle_depth_sorter i_dut (.*);

  initial clk = 0;
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    rst = 1; in_valid = 0; out_stall = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    action = '0; pos_x = 0; pos_y = 0; pos_z = 0; birth_seq = 0; sort_mode = 0;
    additive_blend = 0; rank = 0;
  end

  always @(posedge clk) begin
    if (rst || hold_off) out_stall <= hold_off;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_beat('{entry_index, entry_key, entry_count, dropped, rank_valid});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] act, logic signed [POS_W-1:0] px,
      logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz, logic [BIRTH_W-1:0] bo,
      logic [2:0] md, logic add, logic [RANK_W-1:0] rk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; action <= act; pos_x <= px; pos_y <= py; pos_z <= pz;
    birth_seq <= bo; sort_mode <= md; additive_blend <= add; rank <= rk;
    do @(posedge clk); while (in_stall);
    sb.note_beat(act, px, py, pz, bo, md, add, rk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1; cfg_index <= r; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(r, v);
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(20)) <<< 16;
    endcase
  endfunction

  function automatic logic [FWD_W-1:0] rand_fwd();
    return FWD_W'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic send_random(int n_ins_pct);
    int pick;
    logic [1:0] act;
    pick = $urandom_range(99);
    if (pick < n_ins_pct) act = ACT_INSERT;
    else if (pick < 97) act = ACT_READ;
    else if (pick < 99) act = ACT_NONE;
    else act = ACT_CLEAR;
    send_beat(act, rand_pos(), rand_pos(), rand_pos(),
      $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(8)),
      3'($urandom_range(7)), 1'($urandom_range(1)),
      $urandom_range(3) == 0 ? 10'($urandom) : 10'($urandom_range(sb.held + 1)));
  endtask

  task automatic run_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct; recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0) send_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      else send_random(60);
    end
    drain();
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every mode, ties, empty reads, undefined codes
    send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    send_beat(ACT_INSERT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'hffff, MODE_FAR, 0, 0);
    send_beat(ACT_INSERT, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff, MODE_NEAR, 1, 0);
    send_beat(ACT_INSERT, 5, 5, 5, 16'hffff, MODE_BIRTH_DESC, 0, 0);
    send_beat(ACT_INSERT, 5, 5, 5, 16'hffff, MODE_BIRTH_DESC, 0, 0);
    send_beat(ACT_INSERT, 0, 0, -1, 0, MODE_BIRTH_ASC, 0, 0);
    send_beat(ACT_INSERT, 0, 0, 3, 7, MODE_NONE, 1, 0);
    send_beat(ACT_INSERT, 0, 0, 3, 7, MODE_NONE, 0, 0);
    send_beat(ACT_INSERT, 1, 1, 1, 1, 3'd7, 1, 0);
    send_beat(ACT_INSERT, 1, 1, 1, 1, 3'd5, 0, 0);
    for (int r = 0; r < 10; r++) send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, r);
    send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 10'h3ff);
    send_beat(ACT_NONE, 0, 0, 0, 0, 0, 0, 0);
    send_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    drain();

    write_reg(REG_CAM_X, 32'h80000000);
    write_reg(REG_CAM_Y, 32'h7fffffff);
    write_reg(REG_CAM_Z, 32'h80000000);
    write_reg(REG_FWD_X, 16'hc000);
    write_reg(REG_FWD_Y, 16'h4000);
    write_reg(REG_FWD_Z, 16'hc000);
    run_phase(70, 27, 65);

    write_reg(REG_CAM_X, $urandom);
    write_reg(REG_CAM_Y, $urandom);
    write_reg(REG_CAM_Z, $urandom);
    write_reg(REG_FWD_X, rand_fwd());
    write_reg(REG_FWD_Y, rand_fwd());
    write_reg(REG_FWD_Z, rand_fwd());
    run_phase(70, 65, 27);

    // long receiver hold-off while the sender keeps offering beats
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      run_phase(20, 0, 0);
    join

    write_reg(REG_FWD_X, 0);
    write_reg(REG_FWD_Y, 0);
    write_reg(REG_FWD_Z, 16'h4000);
    write_reg(REG_CAM_X, 0);
    write_reg(REG_CAM_Y, 0);
    write_reg(REG_CAM_Z, 0);
    send_beat(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    // fill the list to capacity and past it; each new entry has a smaller key than all before it
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < DEPTH + 4; i++)
      send_beat(ACT_INSERT, 0, 0, -i, 16'($urandom), MODE_FAR, 0, 0);
    send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 10'h3ff);
    send_beat(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    drain();

    run_phase(50, 0, 0);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
